// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/core/fft_pkg.sv
//------------------------------------------------------------------------------
// fft_pkg: constants and types of the FOC frame transform
// Fixed-point constants, CORDIC arctangent table and stage payload types.
//------------------------------------------------------------------------------
`default_nettype none
package fft_pkg;
	localparam int FracBitsDef     = 24;
	localparam int CordicStagesDef = 24;
	localparam int AtanEntries     = 30;
	localparam int CW              = 36; // CORDIC datapath width, 30 fraction bits

	typedef enum logic [1:0] {
		OP_CLARKE  = 2'd0,
		OP_ICLARKE = 2'd1,
		OP_PARK    = 2'd2,
		OP_IPARK   = 2'd3
	} op_t;

	localparam logic signed [35:0] GainQ30   = 36'sh026DD3B6A;
	localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;

	typedef logic [AtanEntries-1:0][31:0] atan_tab_t;
	localparam atan_tab_t AtanQ30 = {
		32'h00000002, 32'h00000004, 32'h00000008, 32'h0000000F, 32'h0000001F,
		32'h0000003F, 32'h0000007F, 32'h000000FF, 32'h000001FF, 32'h000003FF,
		32'h000007FF, 32'h00000FFF, 32'h00001FFF, 32'h00003FFF, 32'h00007FFF,
		32'h0000FFFF, 32'h0001FFFF, 32'h0003FFFF, 32'h0007FFFF, 32'h000FFFFF,
		32'h001FFFFD, 32'h003FFFEA, 32'h007FFF55, 32'h00FFFAAA, 32'h01FFD55B,
		32'h03FEAB76, 32'h07F56EA6, 32'h0FADBAFC, 32'h1DAC6705, 32'h3243F6A8
	};

	// Floor of sqrt(n) for an elaboration-time constant.
	function automatic longint unsigned isqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned rem;
		res  = 0;
		rem  = n;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Payload carried along the cell chain.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic               flip;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cell_t;
endpackage
`default_nettype wire

// File: rtl/core/fft_stream_if.sv
//------------------------------------------------------------------------------
// fft_stream_if: valid/ready channel
// Carries one payload of parameterised width per item.
//------------------------------------------------------------------------------
`default_nettype none
interface fft_stream_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/foc_frame_transform.sv
//------------------------------------------------------------------------------
// foc_frame_transform: Clarke / Park frame transforms
// Angle reduction, a chain of CORDIC cells and a two-stage multiply/sum tail.
//------------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | opcode, in_a, in_b, in_c, theta
// out_ch  | out | out_a, out_b, out_c
// One item is accepted per cycle unless the pipeline holds; an item passes stages
// 1 to 3, the CORDIC cells and both tail stages before its result is offered.
// The whole pipeline advances together and holds while the output register
// is full and not taken, so items flow back to back whenever results are taken.
// Reset clears only the valid flags.
`default_nettype none
`include "assert_macros.svh"
module foc_frame_transform #(
	parameter int CORDIC_STAGES = fft_pkg::CordicStagesDef
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fft_stream_if.sink   in_ch,
	fft_stream_if.source out_ch
);
	localparam int FRAC_BITS = fft_pkg::FracBitsDef;
	localparam int CW = fft_pkg::CW;
	localparam int NS = CORDIC_STAGES;
	localparam longint unsigned One = 64'd1 << FRAC_BITS;
	localparam logic signed [31:0] K1 = 32'((2 * One) / 3);
	localparam logic signed [31:0] K2 = 32'(One / 3);
	localparam logic signed [31:0] K3 = 32'(fft_pkg::isqrt((One * One) / 3));
	localparam logic signed [31:0] R3 = 32'(fft_pkg::isqrt(3 * One * One));
	localparam int Up = 30 - FRAC_BITS;

	logic en;
	logic [1:0]  op_i;
	logic signed [31:0] a_i, b_i, c_i, th_i;
	assign {op_i, a_i, b_i, c_i, th_i} = in_ch.data;

	// stage 1: scale the angle and take its magnitude for the remainder
	logic v_s1, v_s2, v_s3;
	fft_pkg::cell_t d_s1, d_s2, d_s3;
	logic signed [CW+4:0] r_s1;
	logic signed [CW+4:0] rin;
	assign rin = (CW+5)'(th_i) <<< Up;

	// theta*2^Up lies within about +-2^37, i.e. at most ~21 turns of 2pi. The
	// quotient comes from the top bits of |r| times a short reciprocal.
	localparam logic [15:0] Recip = 16'((64'd1 << 48) / 64'(fft_pkg::TwoPiQ30));
	logic [4:0] q_s2;
	logic signed [CW+4:0] rr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	logic [CW+4:0] mag_s1;
	logic [32:0] qprod;
	always_comb qprod = 33'(mag_s1[CW+4:24]) * 33'(Recip);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.op   <= fft_pkg::op_t'(op_i);
			d_s1.a    <= a_i;
			d_s1.b    <= b_i;
			d_s1.c    <= c_i;
			d_s1.flip <= 1'b0;
			d_s1.x    <= '0; d_s1.y <= '0; d_s1.z <= '0;
			r_s1      <= rin;
			mag_s1    <= rin[CW+4] ? (CW+5)'(-rin) : rin;
			// truncated quotient of |r| / 2pi, may be one low
			d_s2      <= d_s1;
			q_s2      <= qprod[28:24];
			rr_s2     <= r_s1;
		end
	end

	function automatic logic signed [CW+4:0] TwoPiQ30w();
		return (CW+5)'(fft_pkg::TwoPiQ30);
	endfunction

	// stage 3: finish remainder, reduce to (-pi, pi], fold to +-pi/2
	logic signed [CW+4:0] m_c, r_c;
	logic [CW+4:0] um;
	logic fl_c;
	fft_pkg::cell_t n_s3;
	always_comb begin
		um = (rr_s2[CW+4] ? (CW+5)'(-rr_s2) : rr_s2) - (CW+5)'(q_s2 * (CW+5)'(TwoPiQ30w()));
		if (um >= (CW+5)'(TwoPiQ30w())) um = um - (CW+5)'(TwoPiQ30w());
		m_c = rr_s2[CW+4] ? -(CW+5)'(um) : (CW+5)'(um);
		r_c = m_c;
		if (r_c < 0) r_c = r_c + (CW+5)'(TwoPiQ30w());
		if (r_c > (CW+5)'(fft_pkg::PiQ30)) r_c = r_c - (CW+5)'(TwoPiQ30w());
		fl_c = 1'b0;
		if (r_c > (CW+5)'(fft_pkg::HalfPiQ30)) begin
			r_c = (CW+5)'(fft_pkg::PiQ30) - r_c; fl_c = 1'b1;
		end else if (r_c < -(CW+5)'(fft_pkg::HalfPiQ30)) begin
			r_c = -(CW+5)'(fft_pkg::PiQ30) - r_c; fl_c = 1'b1;
		end
		n_s3      = d_s2;
		n_s3.flip = fl_c;
		n_s3.x    = fft_pkg::GainQ30;
		n_s3.y    = '0;
		n_s3.z    = CW'(r_c);
	end

	always_ff @(posedge clk) begin
		if (en) d_s3 <= n_s3;
	end

	// CORDIC chain
	logic [NS:0] v_c;
	fft_pkg::cell_t d_c [NS+1];
	assign v_c[0] = v_s3;
	assign d_c[0] = d_s3;
	for (genvar g = 0; g < NS; g++) begin : g_cell
		fft_cordic_cell #(.IDX(g), .RUN(g < fft_pkg::AtanEntries ? 1 : 0)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(v_c[g]), .d_in(d_c[g]), .vld_q(v_c[g+1]), .d_q(d_c[g+1])
		);
	end

	// tail stage 4: sin/cos and the products
	fft_pkg::cell_t e;
	logic signed [31:0] sn, cs;
	assign e  = d_c[NS];
	always_comb begin
		sn = 32'(e.y >>> Up);
		cs = 32'((e.flip ? -e.x : e.x) >>> Up);
	end

	logic signed [31:0] m0, m1, m2, m3, m4;
	logic signed [31:0] ma1, mb1, ma2, mb2;
	always_comb begin
		ma1 = e.a; mb1 = cs; ma2 = e.b; mb2 = sn;
		case (e.op)
			fft_pkg::OP_CLARKE: begin
				ma1 = e.a; mb1 = K1; ma2 = e.b; mb2 = K2;
			end
			fft_pkg::OP_ICLARKE: begin
				ma1 = e.b; mb1 = R3; ma2 = e.b; mb2 = R3;
			end
			default: ;
		endcase
	end

	function automatic logic signed [31:0] fmul(input logic signed [31:0] x,
		input logic signed [31:0] y);
		logic signed [63:0] p;
		p = 64'(x) * 64'(y);
		return 32'(p >>> FRAC_BITS);
	endfunction

	logic v_t1, v_t2;
	fft_pkg::op_t op_t1;
	logic signed [31:0] a_t1, p0_t1, p1_t1, p2_t1, p3_t1;
	always_comb begin
		m0 = fmul(ma1, mb1);
		m1 = fmul(ma2, mb2);
		m2 = fmul(e.op == fft_pkg::OP_CLARKE ? e.c : e.a,
			e.op == fft_pkg::OP_CLARKE ? K2 : sn);
		m3 = fmul(e.op == fft_pkg::OP_CLARKE ? 32'(e.b - e.c) : e.b,
			e.op == fft_pkg::OP_CLARKE ? K3 : cs);
		m4 = 32'(0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0; v_t2 <= 1'b0;
		end else if (en) begin
			v_t1 <= v_c[NS]; v_t2 <= v_t1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_t1 <= e.op; a_t1 <= e.a;
			p0_t1 <= m0; p1_t1 <= m1; p2_t1 <= m2; p3_t1 <= m3 + m4;
		end
	end

	logic signed [31:0] ra, rb, rc, hb;
	always_comb begin
		ra = '0; rb = '0; rc = '0;
		hb = p0_t1 - a_t1;
		case (op_t1)
			fft_pkg::OP_CLARKE: begin
				ra = p0_t1 - p1_t1 - p2_t1; rb = p3_t1;
			end
			fft_pkg::OP_ICLARKE: begin
				ra = a_t1; rb = hb >>> 1; rc = -a_t1 - (hb >>> 1);
			end
			fft_pkg::OP_PARK: begin
				ra = p0_t1 + p1_t1; rb = p3_t1 - p2_t1;
			end
			default: begin
				ra = p0_t1 - p1_t1; rb = p2_t1 + p3_t1;
			end
		endcase
	end

	logic [95:0] res_q;
	always_ff @(posedge clk) begin
		if (en) res_q <= {ra, rb, rc};
	end

	assign en           = !v_t2 || out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = v_t2;
	assign out_ch.data  = res_q;

	`ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
		"result dropped while stalled")
	`ASSERT_CLK(a_rdy, clk, arst_n, in_ch.ready == (!out_ch.valid || out_ch.ready),
		"pipeline enable mismatch")
	`ASSERT_NEXT(a_prop, clk, arst_n, en && v_t1, out_ch.valid,
		"tail item lost")
endmodule
`default_nettype wire

// File: rtl/core/fft_cordic_cell.sv
//------------------------------------------------------------------------------
// fft_cordic_cell: one CORDIC micro-rotation
// Rotates the vector by one arctangent step and passes the item on; with RUN at zero it passes the item on unchanged.
//------------------------------------------------------------------------------
`default_nettype none
module fft_cordic_cell #(
	parameter int IDX = 0,
	parameter int RUN = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_in,
	input  wire fft_pkg::cell_t d_in,
	output logic               vld_q,
	output fft_pkg::cell_t     d_q
);
	localparam int Sh = (IDX < fft_pkg::AtanEntries) ? IDX : 0;
	localparam logic signed [fft_pkg::CW-1:0] At =
		fft_pkg::CW'(signed'({1'b0, fft_pkg::AtanQ30[Sh]}));

	fft_pkg::cell_t nxt;

	always_comb begin
		nxt = d_in;
		if (RUN != 0) begin
			if (!d_in.z[fft_pkg::CW-1]) begin
				nxt.x = d_in.x - (d_in.y >>> Sh);
				nxt.y = d_in.y + (d_in.x >>> Sh);
				nxt.z = d_in.z - At;
			end else begin
				nxt.x = d_in.x + (d_in.y >>> Sh);
				nxt.y = d_in.y - (d_in.x >>> Sh);
				nxt.z = d_in.z + At;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) d_q <= nxt;
	end
endmodule
`default_nettype wire
